// ----- src/thermal_charge_current_limiter_assert.svh -----
// assertion macros shared by the checker of the thermal charge current limiter
`ifndef THERMAL_CHARGE_CURRENT_LIMITER_ASSERT_SVH
`define THERMAL_CHARGE_CURRENT_LIMITER_ASSERT_SVH

// property that is checked only while out of reset
`define TCCL_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// property that is checked on every edge, reset included
`define TCCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tccl_pkg.sv -----
// shared types, constants and register codes of the thermal charge current limiter
package tccl_pkg;

    localparam int TEMP_W     = 9;
    localparam int CUR_W      = 16;
    localparam int KEEP_W     = 8;
    localparam int LVL_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUOT_W     = 8;

    localparam int WINDOW_DEFAULT = 60;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [CUR_W-1:0]         t_cur;
    typedef logic [KEEP_W-1:0]        t_keep;
    typedef logic [LVL_W-1:0]         t_level;

    localparam t_temp TEMP_MIN = -9'sd40;
    localparam t_temp TEMP_MAX = 9'sd150;

    // throttle levels
    localparam t_level LVL0 = 2'd0;
    localparam t_level LVL1 = 2'd1;
    localparam t_level LVL2 = 2'd2;

    // item operations
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 3'd5;

    // register values after reset
    localparam t_temp THR1_RST   = 9'sd55;
    localparam t_temp THR2_RST   = 9'sd57;
    localparam t_cur  LIMIT0_RST = 16'd2554;
    localparam t_cur  LIMIT1_RST = 16'd1400;
    localparam t_cur  LIMIT2_RST = 16'd365;
    localparam t_keep KEEP_RST   = 8'd5;

endpackage

// ----- src/thermal_charge_current_limiter.sv -----
// top level of the thermal charge current limiter: sample window, throttle level, current cap
//
// input channel: i_valid / o_stall carry one request per accepted edge. i_operation selects
// a tick (temperature sample plus discharging flag) or a current request (requested current
// plus battery-responsive flag). output channel: o_valid / i_stall carry one result per
// request, in order: the granted current (zero on a tick), the level after the request and
// the latest windowed average temperature.
// configuration: i_cfg_we writes i_cfg_data into the register picked by i_cfg_idx; unknown
// indexes are dropped. write only while no request is in flight.
// pipeline: a request accepted at an edge passes the input register, running sum,
// divide-by-window multiply and level update / result register, then shows on o_valid.
// throughput: one request per cycle; every stage has its own valid and fills bubbles, so
// new requests keep coming in while a finished result waits on a stalled receiver.
// o_stall rises only once all four stages hold requests and the result is not taken.
// reset (synchronous, active low): empties the pipeline, clears the sample window (through
// per-entry valid bits, no clearing pass), running sum, average, level and both counters,
// and loads the register defaults.
module thermal_charge_current_limiter
    import tccl_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic                  i_discharging,
    input  logic [CUR_W-1:0]      i_requested_current,
    input  logic                  i_battery_responsive,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CUR_W-1:0]      o_granted_current,
    output logic [LVL_W-1:0]      o_level,
    output logic signed [TEMP_W-1:0] o_average_temp
);

    // window geometry
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_LOG = $clog2(WINDOW);
    // running sum spans -40*WINDOW .. 150*WINDOW
    localparam int SUM_W = $clog2(150 * WINDOW + 1) + 1;
    localparam int MAG_W = SUM_W - 1;
    // exact floor(mag / WINDOW) as (mag * MULT) >> SHIFT for any mag below 2**MAG_W
    localparam int SHIFT  = MAG_W + WIN_LOG;
    localparam int MULT   = ((2 ** SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MULT_W = $clog2(MULT + 1);
    localparam int PROD_W = MAG_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW - 1);

    typedef logic signed [SUM_W-1:0] t_sum;

    // configuration registers
    t_temp r_thr1, r_thr2;
    t_cur  r_limit0, r_limit1, r_limit2;
    t_keep r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr1   <= THR1_RST;
            r_thr2   <= THR2_RST;
            r_limit0 <= LIMIT0_RST;
            r_limit1 <= LIMIT1_RST;
            r_limit2 <= LIMIT2_RST;
            r_keep   <= KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THR1:   r_thr1   <= t_temp'(i_cfg_data[TEMP_W-1:0]);
                CFG_THR2:   r_thr2   <= t_temp'(i_cfg_data[TEMP_W-1:0]);
                CFG_LIMIT0: r_limit0 <= i_cfg_data[CUR_W-1:0];
                CFG_LIMIT1: r_limit1 <= i_cfg_data[CUR_W-1:0];
                CFG_LIMIT2: r_limit2 <= i_cfg_data[CUR_W-1:0];
                CFG_KEEP:   r_keep   <= i_cfg_data[KEEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its content moves on
    logic r_v1, r_v2, r_v3, r_ov;
    logic en1, en2, en3, en_out;

    assign en_out = !r_ov || !i_stall;
    assign en3    = !r_v3 || en_out;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1)    r_v1 <= i_valid;
            if (en2)    r_v2 <= r_v1;
            if (en3)    r_v3 <= r_v2;
            if (en_out) r_ov <= r_v3;
        end
    end

    // stage 1: input register, sample saturated to the sensor range
    logic  r_s1_op, r_s1_dis, r_s1_resp;
    t_temp r_s1_temp;
    t_cur  r_s1_req;
    t_temp n_s1_temp;

    always_comb begin
        if (i_temperature < TEMP_MIN) begin
            n_s1_temp = TEMP_MIN;
        end else if (i_temperature > TEMP_MAX) begin
            n_s1_temp = TEMP_MAX;
        end else begin
            n_s1_temp = i_temperature;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op   <= i_operation;
            r_s1_temp <= n_s1_temp;
            r_s1_dis  <= i_discharging;
            r_s1_req  <= i_requested_current;
            r_s1_resp <= i_battery_responsive;
        end
    end

    // sample window: memory plus valid bits; the entry at the write position is read ahead
    // into a register so the oldest sample is ready when the tick leaves stage 1
    t_temp            r_ring [WINDOW];
    logic [WINDOW-1:0] r_ring_vld;
    t_temp            r_ring_rd;
    logic             r_ring_rdv;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] pos_inc, rd_addr;
    logic             ring_we;
    t_temp            old_sample;

    assign ring_we    = r_v1 && en2 && (r_s1_op == OP_TICK);
    assign pos_inc    = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
    assign rd_addr    = ring_we ? pos_inc : r_pos;
    assign old_sample = r_ring_rdv ? r_ring_rd : '0;

    always_ff @(posedge i_clk) begin
        if (ring_we) r_ring[r_pos] <= r_s1_temp;
        // a one-entry window reads back the sample being written
        if (ring_we && (rd_addr == r_pos)) begin
            r_ring_rd <= r_s1_temp;
        end else begin
            r_ring_rd <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_ring_rdv <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (ring_we) begin
                r_ring_vld[r_pos] <= 1'b1;
                r_pos             <= pos_inc;
            end
            r_ring_rdv <= (ring_we && (rd_addr == r_pos)) ? 1'b1 : r_ring_vld[rd_addr];
        end
    end

    // running sum, updated as the tick leaves stage 1
    t_sum r_sum, n_sum;
    logic [MAG_W-1:0] n_mag;

    assign n_sum = r_sum + SUM_W'(r_s1_temp) - SUM_W'(old_sample);
    assign n_mag = n_sum[SUM_W-1] ? MAG_W'(-n_sum) : MAG_W'(n_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (ring_we) begin
            r_sum <= n_sum;
        end
    end

    // stage 2: magnitude and sign of the new sum
    logic             r_s2_op, r_s2_dis, r_s2_resp, r_s2_neg;
    logic [MAG_W-1:0] r_s2_mag;
    t_cur             r_s2_req;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_op   <= r_s1_op;
            r_s2_dis  <= r_s1_dis;
            r_s2_req  <= r_s1_req;
            r_s2_resp <= r_s1_resp;
            r_s2_neg  <= n_sum[SUM_W-1];
            r_s2_mag  <= n_mag;
        end
    end

    // stage 3: reciprocal product for the divide by the window length
    logic              r_s3_op, r_s3_dis, r_s3_resp, r_s3_neg;
    logic [PROD_W-1:0] r_s3_prod;
    t_cur              r_s3_req;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_op   <= r_s2_op;
            r_s3_dis  <= r_s2_dis;
            r_s3_req  <= r_s2_req;
            r_s3_resp <= r_s2_resp;
            r_s3_neg  <= r_s2_neg;
            r_s3_prod <= PROD_W'(r_s2_mag) * PROD_W'(MULT_C);
        end
    end

    // final stage: average, throttle level hysteresis, current cap
    logic [QUOT_W-1:0] quot;
    t_temp  avg_new;
    t_temp  r_avg, n_avg;
    t_level r_level, n_level;
    t_keep  r_up, r_dn, n_up, n_dn;
    t_temp  up_thr, dn_thr;
    t_cur   lim, n_granted;
    logic   up_cond, dn_cond;
    logic   mv_out;

    assign mv_out  = r_v3 && en_out;
    assign quot    = r_s3_prod[SHIFT +: QUOT_W];
    // truncate toward zero: divide the magnitude, then restore the sign
    assign avg_new = r_s3_neg ? -t_temp'({1'b0, quot}) : t_temp'({1'b0, quot});

    // next level up uses the next threshold, going down uses the present one
    assign up_thr  = (r_level == LVL0) ? r_thr1 : r_thr2;
    assign dn_thr  = (r_level == LVL2) ? r_thr2 : r_thr1;
    assign up_cond = (r_level != LVL2) && (avg_new >= up_thr);
    assign dn_cond = (r_level != LVL0) && (avg_new < dn_thr);

    always_comb begin
        case (r_level)
            LVL1:    lim = r_limit1;
            LVL2:    lim = r_limit2;
            default: lim = r_limit0;
        endcase
    end

    always_comb begin
        n_avg     = r_avg;
        n_level   = r_level;
        n_up      = r_up;
        n_dn      = r_dn;
        n_granted = '0;
        if (r_s3_op == OP_TICK) begin
            n_avg = avg_new;
            if (r_s3_dis) begin
                n_level = LVL0;
                n_up    = '0;
                n_dn    = '0;
            end else if (up_cond) begin
                n_dn = '0;
                if (r_up < r_keep) begin
                    n_up = r_up + 1'b1;
                end else begin
                    n_up    = '0;
                    n_level = r_level + 1'b1;
                end
            end else if (dn_cond) begin
                n_up = '0;
                if (r_dn < r_keep) begin
                    n_dn = r_dn + 1'b1;
                end else begin
                    n_dn    = '0;
                    n_level = r_level - 1'b1;
                end
            end else begin
                n_up = '0;
                n_dn = '0;
            end
        end else begin
            n_granted = (r_s3_resp && (r_s3_req > lim)) ? lim : r_s3_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= '0;
            r_level <= LVL0;
            r_up    <= '0;
            r_dn    <= '0;
        end else if (mv_out) begin
            r_avg   <= n_avg;
            r_level <= n_level;
            r_up    <= n_up;
            r_dn    <= n_dn;
        end
    end

    // result register
    t_cur   r_o_granted;
    t_level r_o_level;
    t_temp  r_o_avg;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_granted <= n_granted;
            r_o_level   <= n_level;
            r_o_avg     <= n_avg;
        end
    end

    assign o_valid           = r_ov;
    assign o_granted_current = r_o_granted;
    assign o_level           = r_o_level;
    assign o_average_temp    = r_o_avg;

endmodule

// ----- src/tccl_checker.sv -----
// port-level checker of the thermal charge current limiter and its bind
`include "thermal_charge_current_limiter_assert.svh"

module tccl_checker
    import tccl_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [CUR_W-1:0]      o_granted_current,
    input logic [LVL_W-1:0]      o_level,
    input logic signed [TEMP_W-1:0] o_average_temp
);

    // reset empties the result register
    `TCCL_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "result left after reset")

    // level never goes past the top level
    `TCCL_ASSERT_RUN(a_level_range, i_clk, i_rst_n, o_valid |-> (o_level != 2'd3), "bad level")

    // the windowed average stays inside the sensor range
    `TCCL_ASSERT_RUN(a_avg_range, i_clk, i_rst_n, o_valid |-> ((o_average_temp >= TEMP_MIN) && (o_average_temp <= TEMP_MAX)), "average out of range")

    // a stalled result holds
    `TCCL_ASSERT_RUN(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_granted_current) && $stable(o_level) && $stable(o_average_temp)), "stalled result changed")

endmodule

bind thermal_charge_current_limiter tccl_checker u_tccl_checker (.*);

// ----- tb/tb_top.sv -----
// testbench of the thermal charge current limiter: directed table, then random ticks and requests
module tb_top;
    import tccl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = WINDOW_DEFAULT;
    localparam int SEG_ITEMS   = 315;      // random requests per register setting
    localparam int NUM_SEGS    = 6;
    localparam int CYCLE_LIMIT = 200000;   // far above the slowest correct run
    localparam int TAIL_CYCLES = 8;        // room for the pipeline to empty

    // register indexes past the end of the list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    // one result as the block should deliver it
    typedef struct {
        t_cur   granted;
        t_level level;
        t_temp  avg;
    } cap_result_t;

    // one row of the directed table: a register write or a request,
    // with an expectation typed in only where it is obvious
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [TEMP_W-1:0]     temp;
        logic                  disch;
        t_cur                  req;
        logic                  resp;
        logic                  typed;
        t_cur                  g_exp;
        t_level                l_exp;
        logic [TEMP_W-1:0]     a_exp;
    } dir_row_t;

    localparam int DIR_ROWS = 39;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // fresh out of reset: cap at the level 0 limit, average still zero
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'hFFFF, 1'b1,
          1'b1, 16'd2554, LVL0, 9'h0},
        // battery not answering: no cap
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'hFFFF, 1'b0,
          1'b1, 16'hFFFF, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b1, 16'h0000, 1'b1,
          1'b1, 16'd0, LVL0, 9'h0},
        // request exactly at the limit
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'd2554, 1'b1,
          1'b1, 16'd2554, LVL0, 9'h0},
        // sample extremes and saturation on both sides
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd150, 1'b0, 16'hA5A5, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, -9'sd40, 1'b0, 16'h5A5A, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'h0FF, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'h100, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, -9'sd41, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd151, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd150, 1'b1, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        // lowest thresholds, no persistence: climb one level per tick
        '{1'b1, CFG_THR1, 16'hFFD8, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_THR2, 16'h0000, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_KEEP, 16'h0000, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_SPARE6, 16'hFFFF, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_SPARE7, 16'h0000, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd100, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd100, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'hFFFF, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        // discharging drops straight back to level 0
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd100, 1'b1, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        // thresholds in odd order, one tick of persistence
        '{1'b1, CFG_THR1, 16'd20, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_THR2, 16'd10, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_KEEP, 16'hFF01, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd150, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd150, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd150, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'd1000, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        // highest thresholds: the falling side
        '{1'b1, CFG_THR1, 16'd150, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_THR2, 16'd150, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_KEEP, 16'h0000, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'hFFFF, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        // limit extremes
        '{1'b1, CFG_LIMIT0, 16'h0000, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_LIMIT1, 16'hFFFF, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b1, CFG_LIMIT2, 16'h0001, OP_TICK, 9'h0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'hFFFF, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_REQUEST, 9'h0, 1'b0, 16'h0001, 1'b1,
          1'b0, 16'h0, LVL0, 9'h0},
        '{1'b0, CFG_THR1, 16'h0, OP_TICK, 9'sd0, 1'b0, 16'h0, 1'b0,
          1'b0, 16'h0, LVL0, 9'h0}
    };

    // dut ports, all inputs driven from time zero
    logic                  i_clk                = 1'b0;
    logic                  i_rst_n              = 1'b0;
    logic                  i_cfg_we             = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx            = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data           = '0;
    logic                  i_valid              = 1'b0;
    logic                  o_stall;
    logic                  i_operation          = OP_TICK;
    logic [TEMP_W-1:0]     i_temperature        = '0;
    logic                  i_discharging        = 1'b0;
    t_cur                  i_requested_current  = '0;
    logic                  i_battery_responsive = 1'b0;
    logic                  o_valid;
    logic                  i_stall              = 1'b0;
    t_cur                  o_granted_current;
    t_level                o_level;
    logic [TEMP_W-1:0]     o_average_temp;

    thermal_charge_current_limiter #(
        .WINDOW (WINDOW)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_operation          (i_operation),
        .i_temperature        (i_temperature),
        .i_discharging        (i_discharging),
        .i_requested_current  (i_requested_current),
        .i_battery_responsive (i_battery_responsive),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_granted_current    (o_granted_current),
        .o_level              (o_level),
        .o_average_temp       (o_average_temp)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    t_temp mdl_thr1  = THR1_RST;
    t_temp mdl_thr2  = THR2_RST;
    t_cur  mdl_lim0  = LIMIT0_RST;
    t_cur  mdl_lim1  = LIMIT1_RST;
    t_cur  mdl_lim2  = LIMIT2_RST;
    t_keep mdl_keep  = KEEP_RST;

    // predictor copy of the window and the throttle state
    int     mdl_ring [WINDOW];
    int     mdl_pos      = 0;
    int     mdl_sum      = 0;
    int     mdl_avg      = 0;
    t_level mdl_lvl      = LVL0;
    int     mdl_up_cnt   = 0;
    int     mdl_down_cnt = 0;

    cap_result_t cap_results_q [$];   // results still owed by the block, oldest first

    int send_idle    = 0;   // percent of cycles the sender holds back
    int recv_idle    = 0;   // percent of cycles the receiver stalls
    int err_cnt      = 0;
    int checked_cnt  = 0;
    int tick_cnt     = 0;
    int req_cnt      = 0;
    int level_moves  = 0;
    int setting_cnt  = 0;
    int cycle_cnt    = 0;

    // limit that applies at the present level
    function automatic t_cur level_cap(t_level lvl);
        if (lvl == LVL1) begin
            return mdl_lim1;
        end else if (lvl == LVL2) begin
            return mdl_lim2;
        end
        return mdl_lim0;
    endfunction

    // advance the predictor by one accepted request and return what it should produce
    function automatic cap_result_t limiter_step(logic op, logic [TEMP_W-1:0] temp,
                                                 logic disch, t_cur req, logic resp);
        cap_result_t r;
        int          sample;
        int          next_thr;
        int          cur_thr;
        t_cur        cap;
        r.granted = '0;
        if (op == OP_TICK) begin
            tick_cnt++;
            // sign-extend and saturate the sample into the legal range
            sample = int'(t_temp'(temp));
            if (sample < int'(TEMP_MIN)) begin
                sample = int'(TEMP_MIN);
            end
            if (sample > int'(TEMP_MAX)) begin
                sample = int'(TEMP_MAX);
            end
            mdl_sum = mdl_sum + sample - mdl_ring[mdl_pos];
            mdl_ring[mdl_pos] = sample;
            mdl_pos = (mdl_pos + 1 >= WINDOW) ? 0 : mdl_pos + 1;
            mdl_avg = mdl_sum / WINDOW;   // truncates toward zero
            next_thr = (mdl_lvl == LVL0) ? int'(mdl_thr1) : int'(mdl_thr2);
            cur_thr  = (mdl_lvl == LVL1) ? int'(mdl_thr1) : int'(mdl_thr2);
            if (disch) begin
                // discharging: sample kept, level and counters cleared
                if (mdl_lvl != LVL0) begin
                    level_moves++;
                end
                mdl_lvl      = LVL0;
                mdl_up_cnt   = 0;
                mdl_down_cnt = 0;
            end else if (mdl_lvl != LVL2 && mdl_avg >= next_thr) begin
                mdl_down_cnt = 0;
                if (mdl_up_cnt < int'(mdl_keep)) begin
                    mdl_up_cnt++;
                end else begin
                    mdl_up_cnt = 0;
                    mdl_lvl    = mdl_lvl + 1'b1;
                    level_moves++;
                end
            end else if (mdl_lvl != LVL0 && mdl_avg < cur_thr) begin
                mdl_up_cnt = 0;
                if (mdl_down_cnt < int'(mdl_keep)) begin
                    mdl_down_cnt++;
                end else begin
                    mdl_down_cnt = 0;
                    mdl_lvl      = mdl_lvl - 1'b1;
                    level_moves++;
                end
            end else begin
                mdl_up_cnt   = 0;
                mdl_down_cnt = 0;
            end
        end else begin
            req_cnt++;
            cap = level_cap(mdl_lvl);
            r.granted = (resp && req > cap) ? cap : req;
        end
        r.level = mdl_lvl;
        r.avg   = t_temp'(mdl_avg);
        return r;
    endfunction

    // offer one request, hold it until taken, then account for it; called at a falling edge
    task automatic send_request(logic op, logic [TEMP_W-1:0] temp, logic disch,
                                t_cur req, logic resp, logic typed, cap_result_t typed_r);
        cap_result_t r;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid              <= 1'b1;
        i_operation          <= op;
        i_temperature        <= temp;
        i_discharging        <= disch;
        i_requested_current  <= req;
        i_battery_responsive <= resp;
        // o_stall read here still holds its value from before the edge
        do begin
            @(posedge i_clk);
        end while (o_stall);
        r = limiter_step(op, temp, disch, req, resp);
        cap_results_q.push_back(typed ? typed_r : r);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every owed result has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        while (cap_results_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // one register write; leaves the write enable high for a following write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_THR1:   mdl_thr1 = t_temp'(data[TEMP_W-1:0]);
            CFG_THR2:   mdl_thr2 = t_temp'(data[TEMP_W-1:0]);
            CFG_LIMIT0: mdl_lim0 = data[CUR_W-1:0];
            CFG_LIMIT1: mdl_lim1 = data[CUR_W-1:0];
            CFG_LIMIT2: mdl_lim2 = data[CUR_W-1:0];
            CFG_KEEP:   mdl_keep = data[KEEP_W-1:0];
            default: ;  // beyond the list: dropped
        endcase
        @(negedge i_clk);
    endtask

    // drain, then load a whole register setting; upper data bits carry junk
    task automatic load_setting(int thr1, int thr2, int lim0, int lim1, int lim2, int keep);
        logic [CFG_DATA_W-1:0] d;
        drain_results();
        setting_cnt++;
        d = CFG_DATA_W'($urandom);
        d[TEMP_W-1:0] = thr1[TEMP_W-1:0];
        cfg_write(CFG_THR1, d);
        d = CFG_DATA_W'($urandom);
        d[TEMP_W-1:0] = thr2[TEMP_W-1:0];
        cfg_write(CFG_THR2, d);
        cfg_write(CFG_LIMIT0, lim0[CFG_DATA_W-1:0]);
        cfg_write(CFG_LIMIT1, lim1[CFG_DATA_W-1:0]);
        cfg_write(CFG_LIMIT2, lim2[CFG_DATA_W-1:0]);
        d = CFG_DATA_W'($urandom);
        d[KEEP_W-1:0] = keep[KEEP_W-1:0];
        cfg_write(CFG_KEEP, d);
        cfg_write(CFG_SPARE6, CFG_DATA_W'($urandom));
        cfg_write(CFG_SPARE7, CFG_DATA_W'($urandom));
    endtask

    // pick the idle pattern: receiver-heavy, sender-heavy, or none
    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin
                send_idle = 35;
                recv_idle = 54;
            end
            1: begin
                send_idle = 54;
                recv_idle = 35;
            end
            default: begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    // receiver side: random stall, changed only at falling edges
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // result checker: compare every taken result with the oldest expectation
    cap_result_t mon_exp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (cap_results_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none expected, granted %0d level %0d average %0d",
                         $time, o_granted_current, o_level, $signed(o_average_temp));
            end else begin
                mon_exp = cap_results_q.pop_front();
                checked_cnt++;
                if (o_granted_current !== mon_exp.granted) begin
                    err_cnt++;
                    $display("%0t: granted current mismatch, expected %0d, actual %0d",
                             $time, mon_exp.granted, o_granted_current);
                end
                if (o_level !== mon_exp.level) begin
                    err_cnt++;
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, mon_exp.level, o_level);
                end
                if (o_average_temp !== mon_exp.avg) begin
                    err_cnt++;
                    $display("%0t: average temperature mismatch, expected %0d, actual %0d",
                             $time, mon_exp.avg, $signed(o_average_temp));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("thermal_charge_current_limiter test failed");
            $finish;
        end
    end

    initial begin
        cap_result_t       typed_r;
        dir_row_t          row;
        logic              prev_cfg;
        int                walk;
        int                target;
        int                req_i;
        int                thr1_v;
        int                thr2_v;
        logic [TEMP_W-1:0] temp_v;
        t_cur              cap_now;
        for (int k = 0; k < WINDOW; k++) begin
            mdl_ring[k] = 0;
        end
        set_idle_mode(0);
        // synchronous reset held at the start
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        prev_cfg = 1'b0;
        setting_cnt = 1;
        foreach (DIR_TAB[r]) begin
            row = DIR_TAB[r];
            if (row.is_cfg) begin
                if (!prev_cfg) begin
                    drain_results();
                    setting_cnt++;
                end
                cfg_write(row.idx, row.data);
            end else begin
                typed_r.granted = row.g_exp;
                typed_r.level   = row.l_exp;
                typed_r.avg     = t_temp'(row.a_exp);
                send_request(row.op, row.temp, row.disch, row.req, row.resp,
                             row.typed, typed_r);
            end
            prev_cfg = row.is_cfg;
        end

        // random part, one register setting per segment
        walk   = 25;
        target = 60;
        for (int s = 0; s < NUM_SEGS; s++) begin
            case (s)
                0: load_setting(-40, 150, 0, 65535, 1, 0);
                1: load_setting(60, 40, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), 1);
                2: load_setting(20, 30, 65535, 32768, 0, 3);
                3: load_setting(55, 57, 2554, 1400, 365, 255);
                4: load_setting(150, -40, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), 2);
                default: begin
                    thr1_v = int'($urandom_range(0, 190)) - 40;
                    thr2_v = int'($urandom_range(0, 190)) - 40;
                    load_setting(thr1_v, thr2_v, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 7));
                end
            endcase
            set_idle_mode(s % 3);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 30) begin
                    // current request: half full-range, half hugging the present limit
                    cap_now = level_cap(mdl_lvl);
                    if ($urandom_range(0, 1) == 0) begin
                        req_i = int'($urandom_range(0, 65535));
                    end else begin
                        req_i = int'(cap_now) + int'($urandom_range(0, 6)) - 3;
                        if (req_i < 0) begin
                            req_i = 0;
                        end
                        if (req_i > 65535) begin
                            req_i = 65535;
                        end
                    end
                    send_request(OP_REQUEST, TEMP_W'($urandom), 1'($urandom), t_cur'(req_i),
                                 1'($urandom), 1'b0, typed_r);
                end else begin
                    // tick: a slow walk that dwells around the thresholds so the
                    // average crosses them, with some raw out-of-range noise
                    if ($urandom_range(0, 79) == 0) begin
                        case ($urandom_range(0, 5))
                            0: target = int'(mdl_thr1) + int'($urandom_range(0, 10)) - 5;
                            1: target = int'(mdl_thr2) + int'($urandom_range(0, 10)) - 5;
                            2: target = int'(TEMP_MIN);
                            3: target = int'(TEMP_MAX);
                            default: target = int'($urandom_range(0, 190)) - 40;
                        endcase
                    end
                    if (walk < target) begin
                        walk = walk + int'($urandom_range(0, 3));
                    end else if (walk > target) begin
                        walk = walk - int'($urandom_range(0, 3));
                    end
                    walk = walk + int'($urandom_range(0, 4)) - 2;
                    if (walk < int'(TEMP_MIN)) begin
                        walk = int'(TEMP_MIN);
                    end
                    if (walk > int'(TEMP_MAX)) begin
                        walk = int'(TEMP_MAX);
                    end
                    if ($urandom_range(0, 99) < 6) begin
                        temp_v = TEMP_W'($urandom);
                    end else begin
                        temp_v = walk[TEMP_W-1:0];
                    end
                    send_request(OP_TICK, temp_v, ($urandom_range(0, 99) < 3),
                                 t_cur'($urandom), 1'($urandom), 1'b0, typed_r);
                end
            end
        end

        // let everything owed come out, then watch a little longer for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks and %0d current requests over %0d register settings,",
                 tick_cnt, req_cnt, setting_cnt);
        $display("%0d level moves predicted, %0d results checked, %0d mismatches",
                 level_moves, checked_cnt, err_cnt);
        if (err_cnt == 0 && cap_results_q.size() == 0) begin
            $display("thermal_charge_current_limiter test passed");
        end else begin
            $display("thermal_charge_current_limiter test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/tccl_pkg.sv
src/thermal_charge_current_limiter.sv
src/tccl_checker.sv
tb/tb_top.sv
